[rtl/core/assert_macros.svh]
// Assertion macros shared by the software timer table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent assertion on the block clock clk_i and reset rst_ni.
`define ASSERT_ON(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

[rtl/core/stt_pkg.sv]
// Package with types, codes and default sizes of the software timer table.
`default_nettype none

package stt_pkg;

  localparam int unsigned TimerSlotsDefault  = 8;
  localparam int unsigned TimeBitsDefault    = 32;
  localparam int unsigned HandlerBitsDefault = 8;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_ZERO_TIME = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  typedef struct packed {
    logic update;
    logic fire;
    logic insert;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic more;
    logic free;
  } tok_flags_t;

endpackage

`default_nettype wire

[rtl/core/stt_cell.sv]
// One timer slot cell that also forwards the search word along the chain.
`default_nettype none

`include "assert_macros.svh"

module stt_cell import stt_pkg::*; #(
  parameter int unsigned TIME_BITS    = TimeBitsDefault,
  parameter int unsigned HANDLER_BITS = HandlerBitsDefault,
  parameter int unsigned SLOT_BITS    = 3,
  parameter logic [SLOT_BITS-1:0] SlotId = '0
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  input  wire logic [SLOT_BITS-1:0]    sel_i,
  input  wire logic [TIME_BITS-1:0]    elapsed_i,
  input  wire logic [TIME_BITS-1:0]    initial_time_i,
  input  wire logic [TIME_BITS-1:0]    reload_period_i,
  input  wire logic                    one_shot_i,
  input  wire logic [HANDLER_BITS-1:0] handler_id_i,
  input  wire tok_flags_t              tok_flags_i,
  input  wire logic [TIME_BITS-1:0]    tok_val_i,
  input  wire logic [SLOT_BITS-1:0]    tok_idx_i,
  input  wire logic [HANDLER_BITS-1:0] tok_hdl_i,
  input  wire logic [SLOT_BITS-1:0]    tok_free_idx_i,
  output tok_flags_t                   tok_flags_o,
  output logic [TIME_BITS-1:0]         tok_val_o,
  output logic [SLOT_BITS-1:0]         tok_idx_o,
  output logic [HANDLER_BITS-1:0]      tok_hdl_o,
  output logic [SLOT_BITS-1:0]         tok_free_idx_o
);

  logic                    active_q, active_d;
  logic                    expired_q, expired_d;
  logic [TIME_BITS-1:0]    remaining_q, remaining_d;
  logic [TIME_BITS-1:0]    period_q, period_d;
  logic                    oneshot_q, oneshot_d;
  logic [HANDLER_BITS-1:0] handler_q, handler_d;
  logic                    hit;
  logic                    take;

  tok_flags_t              tok_flags_q, tok_flags_d;
  logic [TIME_BITS-1:0]    tok_val_q, tok_val_d;
  logic [SLOT_BITS-1:0]    tok_idx_q, tok_idx_d;
  logic [HANDLER_BITS-1:0] tok_hdl_q, tok_hdl_d;
  logic [SLOT_BITS-1:0]    tok_free_idx_q, tok_free_idx_d;

  assign hit = (sel_i == SlotId);

  always_comb begin
    active_d    = active_q;
    expired_d   = expired_q;
    remaining_d = remaining_q;
    period_d    = period_q;
    oneshot_d   = oneshot_q;
    handler_d   = handler_q;
    if (cmd_i.update && active_q) begin
      if (remaining_q <= elapsed_i) begin
        expired_d = 1'b1;
      end else begin
        remaining_d = remaining_q - elapsed_i;
      end
    end
    if (cmd_i.fire && hit) begin
      expired_d = 1'b0;
      if (oneshot_q || (period_q == '0)) begin
        active_d = 1'b0;
      end else begin
        remaining_d = period_q;
      end
    end
    if (cmd_i.insert && hit) begin
      active_d    = 1'b1;
      remaining_d = initial_time_i;
      period_d    = reload_period_i;
      oneshot_d   = one_shot_i;
      handler_d   = handler_id_i;
    end
  end

  // The earliest expired slot wins; on equal times the word from a lower slot is kept.
  assign take = expired_q && (!tok_flags_i.found || (remaining_q < tok_val_i));

  always_comb begin
    tok_flags_d.found = tok_flags_i.found | expired_q;
    tok_flags_d.more  = tok_flags_i.more | (tok_flags_i.found & expired_q);
    tok_flags_d.free  = tok_flags_i.free | !active_q;
    tok_val_d         = take ? remaining_q : tok_val_i;
    tok_idx_d         = take ? SlotId : tok_idx_i;
    tok_hdl_d         = take ? handler_q : tok_hdl_i;
    tok_free_idx_d    = (!tok_flags_i.free && !active_q) ? SlotId : tok_free_idx_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      expired_q   <= 1'b0;
      tok_flags_q <= '0;
    end else begin
      active_q    <= active_d;
      expired_q   <= expired_d;
      tok_flags_q <= tok_flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    remaining_q    <= remaining_d;
    period_q       <= period_d;
    oneshot_q      <= oneshot_d;
    handler_q      <= handler_d;
    tok_val_q      <= tok_val_d;
    tok_idx_q      <= tok_idx_d;
    tok_hdl_q      <= tok_hdl_d;
    tok_free_idx_q <= tok_free_idx_d;
  end

  assign tok_flags_o    = tok_flags_q;
  assign tok_val_o      = tok_val_q;
  assign tok_idx_o      = tok_idx_q;
  assign tok_hdl_o      = tok_hdl_q;
  assign tok_free_idx_o = tok_free_idx_q;

  `ASSERT_ON(a_fire_needs_expired, (cmd_i.fire && hit) |-> expired_q,
             "A slot fired that had not expired.")
  `ASSERT_ON(a_insert_needs_free, (cmd_i.insert && hit) |-> !active_q,
             "An insert overwrote an active slot.")
  `ASSERT_ON(a_expired_is_active, expired_q |-> active_q,
             "An inactive slot is marked expired.")

endmodule

`default_nettype wire

[rtl/core/software_timer_table_unit.sv]
// Top level of the software timer table: slot cell chain and its sequencer.
`default_nettype none

`include "assert_macros.svh"

// An item is taken when start is high and busy is low; the elapsed time is applied
// to every active slot at that edge. A search word then walks the row of slot
// cells, one cell per cycle, and the sequencer acts on its outcome in the decide
// state. One search is run for each fired timer, and one more for an insert that
// follows fired timers; an item that fires nothing still runs one search, and busy
// stays high until its last search is done. Results appear on the result ports
// for a single cycle, marked by result_valid_o, in order and with last_o on the
// final one; the receiver must take each result in the cycle it is shown, since
// nothing holds a result back. A tick that fires nothing gives no result.
module software_timer_table_unit import stt_pkg::*; #(
  parameter int unsigned TIMER_SLOTS  = TimerSlotsDefault,
  parameter int unsigned TIME_BITS    = TimeBitsDefault,
  parameter int unsigned HANDLER_BITS = HandlerBitsDefault,
  localparam int unsigned SlotBits    = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    op_i,
  input  wire logic [TIME_BITS-1:0]    elapsed_i,
  input  wire logic [TIME_BITS-1:0]    initial_time_i,
  input  wire logic [TIME_BITS-1:0]    reload_period_i,
  input  wire logic                    one_shot_i,
  input  wire logic [HANDLER_BITS-1:0] handler_id_i,
  output logic                         result_valid_o,
  output logic                         kind_o,
  output logic [HANDLER_BITS-1:0]      fired_handler_o,
  output logic [SlotBits-1:0]          slot_index_o,
  output logic [1:0]                   status_o,
  output logic                         last_o
);

  state_e                  state_q, state_d;
  logic [SlotBits-1:0]     cnt_q, cnt_d;
  logic                    op_q;
  logic [TIME_BITS-1:0]    init_q;
  logic [TIME_BITS-1:0]    period_q;
  logic                    oneshot_q;
  logic [HANDLER_BITS-1:0] hdl_q;

  logic                    accept;
  logic                    decide;
  logic                    found;
  logic                    insert_ok;
  cmd_t                    cmd;
  logic [SlotBits-1:0]     sel;
  logic [TIME_BITS-1:0]    ins_time;
  logic [TIME_BITS-1:0]    ins_period;
  logic                    ins_oneshot;
  logic [HANDLER_BITS-1:0] ins_hdl;
  status_e                 status;

  tok_flags_t              tok_flags    [TIMER_SLOTS+1];
  logic [TIME_BITS-1:0]    tok_val      [TIMER_SLOTS+1];
  logic [SlotBits-1:0]     tok_idx      [TIMER_SLOTS+1];
  logic [HANDLER_BITS-1:0] tok_hdl      [TIMER_SLOTS+1];
  logic [SlotBits-1:0]     tok_free_idx [TIMER_SLOTS+1];

  assign tok_flags[0]    = '0;
  assign tok_val[0]      = '0;
  assign tok_idx[0]      = '0;
  assign tok_hdl[0]      = '0;
  assign tok_free_idx[0] = '0;

  assign accept = start && !busy;
  assign decide = (state_q == ST_DECIDE);
  assign found  = tok_flags[TIMER_SLOTS].found;

  assign insert_ok = decide && !found && (op_q == OP_INSERT) && (init_q != '0)
                     && tok_flags[TIMER_SLOTS].free;

  assign cmd.update = accept;
  assign cmd.fire   = decide && found;
  assign cmd.insert = insert_ok;
  assign sel        = found ? tok_idx[TIMER_SLOTS] : tok_free_idx[TIMER_SLOTS];

  assign ins_time    = init_q;
  assign ins_period  = period_q;
  assign ins_oneshot = oneshot_q;
  assign ins_hdl     = hdl_q;

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    stt_cell #(
      .TIME_BITS   (TIME_BITS),
      .HANDLER_BITS(HANDLER_BITS),
      .SLOT_BITS   (SlotBits),
      .SlotId      (SlotBits'(i))
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .cmd_i          (cmd),
      .sel_i          (sel),
      .elapsed_i      (elapsed_i),
      .initial_time_i (ins_time),
      .reload_period_i(ins_period),
      .one_shot_i     (ins_oneshot),
      .handler_id_i   (ins_hdl),
      .tok_flags_i    (tok_flags[i]),
      .tok_val_i      (tok_val[i]),
      .tok_idx_i      (tok_idx[i]),
      .tok_hdl_i      (tok_hdl[i]),
      .tok_free_idx_i (tok_free_idx[i]),
      .tok_flags_o    (tok_flags[i+1]),
      .tok_val_o      (tok_val[i+1]),
      .tok_idx_o      (tok_idx[i+1]),
      .tok_hdl_o      (tok_hdl[i+1]),
      .tok_free_idx_o (tok_free_idx[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SlotBits'(TIMER_SLOTS - 1)) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cnt_d = '0;
        if (found && (tok_flags[TIMER_SLOTS].more || (op_q == OP_INSERT))) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= op_i;
      init_q    <= initial_time_i;
      period_q  <= reload_period_i;
      oneshot_q <= one_shot_i;
      hdl_q     <= handler_id_i;
    end
  end

  always_comb begin
    if (found || (init_q != '0 && tok_flags[TIMER_SLOTS].free)) begin
      status = STATUS_OK;
    end else if (init_q == '0) begin
      status = STATUS_ZERO_TIME;
    end else begin
      status = STATUS_FULL;
    end
  end

  assign busy            = (state_q != ST_IDLE);
  assign result_valid_o  = decide && (found || (op_q == OP_INSERT));
  assign kind_o          = found ? KIND_FIRED : KIND_STATUS;
  assign fired_handler_o = found ? tok_hdl[TIMER_SLOTS] : '0;
  assign slot_index_o    = (found || insert_ok) ? sel : '0;
  assign status_o        = status;
  assign last_o          = found ? (!tok_flags[TIMER_SLOTS].more && (op_q != OP_INSERT))
                                 : 1'b1;

  `ASSERT_ON(a_result_while_busy, result_valid_o |-> busy,
             "A result appeared while the unit was idle.")
  `ASSERT_ON(a_last_ends_item, (result_valid_o && last_o) |=> !busy,
             "The unit stayed busy after the final result.")
  `ASSERT_ON(a_decide_after_scan, decide |-> ($past(state_q) == ST_SCAN),
             "A decision was taken without a completed chain search.")
  `ASSERT_ON(a_accept_goes_busy, accept |=> (busy && !result_valid_o),
             "An accepted word did not start a chain search.")

endmodule

`default_nettype wire

[tb/sv/timer_table_checker.sv]
// Checker that predicts the result words of the software timer table and compares them.
`timescale 1ns / 100ps

module timer_table_checker import stt_pkg::*; #(
  parameter int unsigned SLOTS = TimerSlotsDefault,
  parameter int unsigned TW    = TimeBitsDefault,
  parameter int unsigned HW    = HandlerBitsDefault,
  parameter int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          busy_i,
  input  wire logic          op_i,
  input  wire logic [TW-1:0] elapsed_i,
  input  wire logic [TW-1:0] initial_time_i,
  input  wire logic [TW-1:0] reload_period_i,
  input  wire logic          one_shot_i,
  input  wire logic [HW-1:0] handler_id_i,
  input  wire logic          result_valid_i,
  input  wire logic          kind_i,
  input  wire logic [HW-1:0] fired_handler_i,
  input  wire logic [SW-1:0] slot_index_i,
  input  wire logic [1:0]    status_i,
  input  wire logic          last_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o,
  output int                 fired_words_o,
  output int                 status_words_o,
  output int                 full_words_o,
  output int                 rejected_words_o
);

  typedef struct packed {
    logic          kind;
    logic [HW-1:0] handler;
    logic [SW-1:0] slot;
    status_e       status;
    logic          last;
  } timer_word_t;

  logic          slot_live   [SLOTS];
  logic [TW-1:0] time_left   [SLOTS];
  logic [TW-1:0] reload_time [SLOTS];
  logic          single_shot [SLOTS];
  logic [HW-1:0] owner_id    [SLOTS];

  timer_word_t expected_words [$];

  int mismatches = 0;
  int fired_seen = 0;
  int status_seen = 0;
  int full_seen = 0;
  int rejected_seen = 0;

  task automatic check_field(input string field, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Applies one accepted word to the slot table and queues the result words it causes.
  task automatic predict_timer_words(input logic op_v, input logic [TW-1:0] elapsed_v,
                                     input logic [TW-1:0] init_v,
                                     input logic [TW-1:0] period_v,
                                     input logic once_v, input logic [HW-1:0] hid_v);
    logic [TW-1:0] prior [SLOTS];
    logic          due   [SLOTS];
    timer_word_t   item_words [$];
    timer_word_t   w;
    int            pick;
    int            free_slot;
    for (int i = 0; i < SLOTS; i++) begin
      prior[i] = time_left[i];
      due[i] = 1'b0;
      if (slot_live[i]) begin
        if (time_left[i] <= elapsed_v) begin
          due[i] = 1'b1;
        end else begin
          time_left[i] = time_left[i] - elapsed_v;
        end
      end
    end
    for (int n = 0; n < SLOTS; n++) begin
      pick = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (due[i]) begin
          if (pick < 0) begin
            pick = i;
          end else if (prior[i] < prior[pick]) begin
            pick = i;
          end
        end
      end
      if (pick >= 0) begin
        due[pick] = 1'b0;
        w.kind = KIND_FIRED;
        w.handler = owner_id[pick];
        w.slot = pick[SW-1:0];
        w.status = STATUS_OK;
        w.last = 1'b0;
        item_words.push_back(w);
        if (single_shot[pick] || reload_time[pick] == '0) begin
          slot_live[pick] = 1'b0;
        end else begin
          time_left[pick] = reload_time[pick];
        end
      end
    end
    if (op_v == OP_INSERT) begin
      w.kind = KIND_STATUS;
      w.handler = '0;
      w.slot = '0;
      w.last = 1'b0;
      free_slot = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (!slot_live[i]) begin
          free_slot = i;
        end
      end
      if (init_v == '0) begin
        w.status = STATUS_ZERO_TIME;
      end else if (free_slot < 0) begin
        w.status = STATUS_FULL;
      end else begin
        w.status = STATUS_OK;
        w.slot = free_slot[SW-1:0];
        slot_live[free_slot] = 1'b1;
        time_left[free_slot] = init_v;
        reload_time[free_slot] = period_v;
        single_shot[free_slot] = once_v;
        owner_id[free_slot] = hid_v;
      end
      item_words.push_back(w);
    end
    if (item_words.size() > 0) begin
      w = item_words.pop_back();
      w.last = 1'b1;
      item_words.push_back(w);
    end
    foreach (item_words[k]) begin
      expected_words.push_back(item_words[k]);
    end
  endtask

  // Results are compared before a new word is predicted, since a word accepted at this
  // edge cannot have produced a result yet.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    timer_word_t want;
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
      end
      expected_words.delete();
    end else begin
      if (result_valid_i) begin
        if (expected_words.size() == 0) begin
          $error("Result word with nothing expected: kind %0d, slot %0d, status %0d",
                 kind_i, slot_index_i, status_i);
          mismatches++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind_i));
          check_field("fired_handler", 32'(want.handler), 32'(fired_handler_i));
          check_field("slot_index", 32'(want.slot), 32'(slot_index_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("last", 32'(want.last), 32'(last_i));
          if (want.kind == KIND_FIRED) begin
            fired_seen++;
          end else begin
            status_seen++;
            if (want.status == STATUS_FULL) begin
              full_seen++;
            end else if (want.status == STATUS_ZERO_TIME) begin
              rejected_seen++;
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        predict_timer_words(op_i, elapsed_i, initial_time_i, reload_period_i, one_shot_i,
                            handler_id_i);
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o <= expected_words.size();
    fired_words_o <= fired_seen;
    status_words_o <= status_seen;
    full_words_o <= full_seen;
    rejected_words_o <= rejected_seen;
  end

endmodule

[tb/sv/testbench.sv]
// Top of the software timer table testbench: clock, reset, stimulus and the verdict.
`timescale 1ns / 100ps

module testbench;
  import stt_pkg::*;

  localparam int unsigned SLOTS           = TimerSlotsDefault;
  localparam int unsigned TW              = TimeBitsDefault;
  localparam int unsigned HW              = HandlerBitsDefault;
  localparam int unsigned SW              = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int unsigned RANDOM_ITEMS    = 360;
  localparam int unsigned QUIET_TAIL      = 40;
  localparam int unsigned SETTLE_CYCLES   = 100;
  localparam int unsigned PERIODIC_BUDGET = 3;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic          op;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] initial_time;
  logic [TW-1:0] reload_period;
  logic          one_shot;
  logic [HW-1:0] handler_id;
  logic          result_valid;
  logic          kind;
  logic [HW-1:0] fired_handler;
  logic [SW-1:0] slot_index;
  logic [1:0]    status;
  logic          last;

  int mismatches;
  int outstanding;
  int fired_words;
  int status_words;
  int full_words;
  int rejected_words;
  int items_sent = 0;
  int permanent_timers = 0;
  int cycle_count;
  bit bursty = 1'b0;
  bit crowded = 1'b0;

  software_timer_table_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .start           (start),
    .busy            (busy),
    .op_i            (op),
    .elapsed_i       (elapsed),
    .initial_time_i  (initial_time),
    .reload_period_i (reload_period),
    .one_shot_i      (one_shot),
    .handler_id_i    (handler_id),
    .result_valid_o  (result_valid),
    .kind_o          (kind),
    .fired_handler_o (fired_handler),
    .slot_index_o    (slot_index),
    .status_o        (status),
    .last_o          (last)
  );

  timer_table_checker #(
    .SLOTS (SLOTS),
    .TW    (TW),
    .HW    (HW),
    .SW    (SW)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .op_i             (op),
    .elapsed_i        (elapsed),
    .initial_time_i   (initial_time),
    .reload_period_i  (reload_period),
    .one_shot_i       (one_shot),
    .handler_id_i     (handler_id),
    .result_valid_i   (result_valid),
    .kind_i           (kind),
    .fired_handler_i  (fired_handler),
    .slot_index_i     (slot_index),
    .status_i         (status),
    .last_i           (last),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .fired_words_o    (fired_words),
    .status_words_o   (status_words),
    .full_words_o     (full_words),
    .rejected_words_o (rejected_words)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  task automatic issue_word(input logic op_v, input logic [TW-1:0] elapsed_v,
                            input logic [TW-1:0] init_v, input logic [TW-1:0] period_v,
                            input logic once_v, input logic [HW-1:0] hid_v);
    start <= 1'b1;
    op <= op_v;
    elapsed <= elapsed_v;
    initial_time <= init_v;
    reload_period <= period_v;
    one_shot <= once_v;
    handler_id <= hid_v;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic pause_sender();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // A periodic timer with a nonzero period never leaves the table, so only a few are made.
  task automatic random_item();
    logic [TW-1:0] e;
    logic [TW-1:0] t;
    logic [TW-1:0] p;
    logic          once;
    logic          is_insert;
    int            pick;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      e = '0;
    end else if (pick < 14) begin
      e = $urandom;
    end else if (crowded) begin
      e = $urandom_range(0, 3);
    end else begin
      e = $urandom_range(1, 20);
    end
    is_insert = crowded ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 1) == 1);
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      t = '0;
    end else if (pick < 20) begin
      t = $urandom;
    end else begin
      t = $urandom_range(1, 40);
    end
    once = 1'($urandom_range(0, 1));
    if (once || !is_insert) begin
      p = $urandom;
    end else if (permanent_timers < PERIODIC_BUDGET && $urandom_range(0, 3) == 0) begin
      p = $urandom_range(1, 40);
      if (t != '0) begin
        permanent_timers++;
      end
    end else begin
      p = '0;
    end
    issue_word(is_insert ? OP_INSERT : OP_TICK, e, t, p, once, HW'($urandom));
  endtask

  initial begin
    logic [TW-1:0] fill_times [7];
    fill_times = '{32'hFFFF_FFFF, 32'h8000_0000, 100, 100, 32'h7FFF_FFFF, 50, 1000};
    rst_n = 1'b0;
    start = 1'b0;
    op = OP_TICK;
    elapsed = '0;
    initial_time = '0;
    reload_period = '0;
    one_shot = 1'b0;
    handler_id = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_word(OP_TICK, 0, 0, 0, 1'b0, 8'h00);
    issue_word(OP_INSERT, 0, 0, 32'hFFFF_FFFF, 1'b1, 8'h3C);
    issue_word(OP_INSERT, 0, 5, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    issue_word(OP_INSERT, 0, 5, 0, 1'b0, 8'h00);
    issue_word(OP_INSERT, 0, 2, 3, 1'b0, 8'hA5);
    permanent_timers = 1;
    issue_word(OP_TICK, 0, 0, 0, 1'b0, 8'h00);
    issue_word(OP_TICK, 2, 0, 0, 1'b0, 8'h00);
    issue_word(OP_TICK, 3, 0, 0, 1'b0, 8'h00);
    foreach (fill_times[k]) begin
      issue_word(OP_INSERT, 0, fill_times[k], $urandom, 1'b1, HW'(8'h10 + k));
    end
    issue_word(OP_INSERT, 0, 7, 0, 1'b1, 8'h5A);
    issue_word(OP_INSERT, 0, 0, 0, 1'b1, 8'h01);
    issue_word(OP_INSERT, 50, 32'h1234_5678, 0, 1'b1, 8'h77);
    issue_word(OP_INSERT, 32'hFFFF_FFFF, 1, 0, 1'b1, 8'h81);
    issue_word(OP_TICK, 32'hFFFF_FFFF, 0, 0, 1'b0, 8'h00);
    wait_for_results();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 45 == 0) begin
        bursty = 1'($urandom_range(0, 1));
      end
      if (n % 50 == 0) begin
        crowded = 1'($urandom_range(0, 1));
      end
      if (n == RANDOM_ITEMS / 2) begin
        wait_for_results();
      end else if (bursty && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
        pause_sender();
      end
      random_item();
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d words; checked %0d fired and %0d insert status results.",
             items_sent, fired_words, status_words);
    $display("Inserts met a full table %0d times and a zero initial time %0d times.",
             full_words, rejected_words);
    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: done, clean");
    end else begin
      if (outstanding != 0) begin
        $error("%0d expected results never arrived", outstanding);
      end
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
